/* design/dda_line_rasterizer_top_defines.svh */
// Assertion macros shared by the line rasterizer RTL.
`ifndef DDA_LINE_RASTERIZER_TOP_DEFINES_SVH
`define DDA_LINE_RASTERIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dda_pkg.sv */
// Package with the shared constants and types of the line rasterizer.
`timescale 1ns / 1ps

package dda_pkg;

    // Width of one pixel coordinate, used by the channel fields.
    localparam int COORD_BITS = 10;
    // Default number of fraction bits in the fixed-point position.
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic start;
    } div_ctl_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* design/dda_if.sv */
// Valid/ready channel interfaces for commands and pixels.
`timescale 1ns / 1ps

interface dda_in_if import dda_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, opcode, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dda_out_if import dda_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  pixel_valid;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_valid, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_valid, last_pixel, output ready);
endinterface

/* design/dda_line_rasterizer_top.sv */
// Top level of the DDA line rasterizer: sequencer, position registers, pixel output.
//
//   Channel | Direction | Payload
//   --------+-----------+----------------------------------------------------
//   cmd     | in        | opcode, x_start, y_start, x_end, y_end
//   pix     | out       | pixel_x, pixel_y, pixel_valid, last_pixel
//
// Steps stream at one pixel per cycle while no division runs and pixels are taken.
// A start command whose endpoints differ keeps cmd.ready low after its transfer
// while the shared divider produces the x increment and then the y increment,
// one quotient bit a cycle. Equal-endpoint starts and steps leave the sequencer idle.
// rst_n clears all state asynchronously; the block comes up idle with no line.
// A pixel waiting in the output register only stalls new commands when it is
// not taken in the same cycle.
`timescale 1ns / 1ps
`include "dda_line_rasterizer_top_defines.svh"

module dda_line_rasterizer_top import dda_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    dda_in_if.sink    cmd,
    dda_out_if.source pix
);

    // Position format: sign bit, integer coordinate, fraction.
    localparam int POS_W = COORD_BITS + FRAC_BITS + 1;
    // The increment magnitude is at most one, so it needs one integer bit.
    localparam int QUO_W = FRAC_BITS + 1;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_DIV_X,
        S_DIV_Y
    } state_t;

    state_t                state_reg;
    logic [POS_W-1:0]      x_pos_reg;
    logic [POS_W-1:0]      y_pos_reg;
    logic [POS_W-1:0]      x_inc_reg;
    logic [POS_W-1:0]      y_inc_reg;
    logic [COORD_BITS-1:0] steps_left_reg;
    logic [COORD_BITS-1:0] mag_y_reg;
    logic                  neg_x_reg;
    logic                  neg_y_reg;
    logic                  line_active_reg;

    logic                  pix_valid_reg;
    logic [COORD_BITS-1:0] pix_x_reg;
    logic [COORD_BITS-1:0] pix_y_reg;
    logic                  pix_pv_reg;
    logic                  pix_last_reg;

    logic                  slot_free;
    logic                  take;
    logic                  is_start;
    logic                  neg_x;
    logic                  neg_y;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] steps;
    logic [POS_W-1:0]      x_sum;
    logic [POS_W-1:0]      y_sum;
    logic [COORD_BITS-1:0] steps_dec;
    logic [POS_W-1:0]      quo_ext;
    logic                  cur_neg;
    logic [POS_W-1:0]      inc_val;

    div_ctl_t              div_ctl;
    div_stat_t             div_stat;
    logic [COORD_BITS-1:0] div_mag;
    logic [COORD_BITS-1:0] div_den;
    logic [QUO_W-1:0]      div_quo;

    // Round half up: add one half and keep the integer bits.
    function automatic logic [COORD_BITS-1:0] round_pos(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] s;
        s = p + (POS_W'(1) << (FRAC_BITS - 1));
        return s[FRAC_BITS +: COORD_BITS];
    endfunction

    // New commands are taken only by the idle sequencer and only when the
    // output register is empty or is being emptied in this cycle.
    assign slot_free = !pix_valid_reg || pix.ready;
    assign cmd.ready = (state_reg == S_IDLE) && slot_free;
    assign take      = cmd.valid && cmd.ready;
    assign is_start  = opcode_t'(cmd.opcode) == OP_START;

    // Absolute deltas and direction of each axis for a start command.
    assign neg_x = cmd.x_end < cmd.x_start;
    assign neg_y = cmd.y_end < cmd.y_start;
    assign adx   = neg_x ? (cmd.x_start - cmd.x_end) : (cmd.x_end - cmd.x_start);
    assign ady   = neg_y ? (cmd.y_start - cmd.y_end) : (cmd.y_end - cmd.y_start);
    assign steps = (adx > ady) ? adx : ady;

    // One fixed-point add per axis advances the line by one step.
    assign x_sum     = x_pos_reg + x_inc_reg;
    assign y_sum     = y_pos_reg + y_inc_reg;
    assign steps_dec = steps_left_reg - 1'b1;

    // The divider is launched with the x delta straight from the command and,
    // once that finishes, with the saved y delta. The step count serves as
    // the divisor both times.
    assign div_ctl.start = (take && is_start && (steps != '0))
                        || ((state_reg == S_DIV_X) && div_stat.done);
    assign div_mag = (state_reg == S_IDLE) ? adx : mag_y_reg;
    assign div_den = (state_reg == S_IDLE) ? steps : steps_left_reg;

    dda_div #(
        .MAG_W (COORD_BITS),
        .QUO_W (QUO_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .mag   (div_mag),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // The quotient is a magnitude; the increment takes the sign of the delta.
    assign quo_ext = POS_W'(div_quo);
    assign cur_neg = (state_reg == S_DIV_X) ? neg_x_reg : neg_y_reg;
    assign inc_val = cur_neg ? (POS_W'(0) - quo_ext) : quo_ext;

    assign pix.valid       = pix_valid_reg;
    assign pix.pixel_x     = pix_x_reg;
    assign pix.pixel_y     = pix_y_reg;
    assign pix.pixel_valid = pix_pv_reg;
    assign pix.last_pixel  = pix_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            x_pos_reg       <= '0;
            y_pos_reg       <= '0;
            x_inc_reg       <= '0;
            y_inc_reg       <= '0;
            steps_left_reg  <= '0;
            mag_y_reg       <= '0;
            neg_x_reg       <= 1'b0;
            neg_y_reg       <= 1'b0;
            line_active_reg <= 1'b0;
            pix_valid_reg   <= 1'b0;
            pix_x_reg       <= '0;
            pix_y_reg       <= '0;
            pix_pv_reg      <= 1'b0;
            pix_last_reg    <= 1'b0;
        end
        else
        begin
            // A pixel taken downstream empties the register unless a new
            // command refills it at the same edge.
            if (pix_valid_reg && pix.ready && !take)
            begin
                pix_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        pix_valid_reg <= 1'b1;
                        if (is_start)
                        begin
                            // The start pixel is exact, so it goes out at once
                            // while the increments are still being divided.
                            x_pos_reg      <= {1'b0, cmd.x_start, {FRAC_BITS{1'b0}}};
                            y_pos_reg      <= {1'b0, cmd.y_start, {FRAC_BITS{1'b0}}};
                            steps_left_reg <= steps;
                            mag_y_reg      <= ady;
                            neg_x_reg      <= neg_x;
                            neg_y_reg      <= neg_y;
                            pix_x_reg      <= cmd.x_start;
                            pix_y_reg      <= cmd.y_start;
                            pix_pv_reg     <= 1'b1;
                            if (steps == '0)
                            begin
                                // Equal endpoints: a single pixel that is also last.
                                x_inc_reg       <= '0;
                                y_inc_reg       <= '0;
                                line_active_reg <= 1'b0;
                                pix_last_reg    <= 1'b1;
                            end
                            else
                            begin
                                line_active_reg <= 1'b1;
                                pix_last_reg    <= 1'b0;
                                state_reg       <= S_DIV_X;
                            end
                        end
                        else if (line_active_reg)
                        begin
                            x_pos_reg       <= x_sum;
                            y_pos_reg       <= y_sum;
                            steps_left_reg  <= steps_dec;
                            line_active_reg <= steps_dec != '0;
                            pix_x_reg       <= round_pos(x_sum);
                            pix_y_reg       <= round_pos(y_sum);
                            pix_pv_reg      <= 1'b1;
                            pix_last_reg    <= steps_dec == '0;
                        end
                        else
                        begin
                            // A step with no line in progress reports no pixel.
                            pix_x_reg    <= '0;
                            pix_y_reg    <= '0;
                            pix_pv_reg   <= 1'b0;
                            pix_last_reg <= 1'b0;
                        end
                    end
                end
                S_DIV_X:
                begin
                    if (div_stat.done)
                    begin
                        x_inc_reg <= inc_val;
                        state_reg <= S_DIV_Y;
                    end
                end
                S_DIV_Y:
                begin
                    if (div_stat.done)
                    begin
                        y_inc_reg <= inc_val;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `DDA_ASSERT_NOW(a_ready_only_idle, cmd.ready, state_reg == S_IDLE,
                    "cmd.ready raised outside idle")
    `DDA_ASSERT_NEXT(a_start_runs_div, take && is_start && (steps != '0),
                     div_stat.busy && (state_reg == S_DIV_X),
                     "line start did not launch the divider")
    `DDA_ASSERT_NOW(a_done_in_div, div_stat.done,
                    (state_reg == S_DIV_X) || (state_reg == S_DIV_Y),
                    "divider finished with the sequencer idle")
    `DDA_ASSERT_NOW(a_active_has_steps, line_active_reg, steps_left_reg != '0,
                    "active line with no steps left")

endmodule

/* design/dda_div.sv */
// Restoring divider that yields one quotient bit per cycle.
`timescale 1ns / 1ps

module dda_div import dda_pkg::*;
#(
    parameter int MAG_W = COORD_BITS,
    parameter int QUO_W = FRAC_BITS_DEF + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctl_t         ctl,
    input  logic [MAG_W-1:0] mag,
    input  logic [MAG_W-1:0] den,
    output div_stat_t        stat,
    output logic [QUO_W-1:0] quo
);

    localparam int CNT_W = $clog2(QUO_W);

    logic [MAG_W:0]   rem_reg;
    logic [MAG_W-1:0] den_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic             ge;
    logic [MAG_W:0]   diff;
    logic [MAG_W:0]   kept;
    logic             last;

    // The dividend never exceeds the divisor, so the partial remainder stays
    // below twice the divisor and one extra bit is enough.
    assign ge   = rem_reg >= {1'b0, den_reg};
    assign diff = rem_reg - {1'b0, den_reg};
    assign kept = ge ? diff : rem_reg;
    assign last = cnt_reg == CNT_W'(QUO_W - 1);

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && last;
    assign quo       = {quo_reg[QUO_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            rem_reg  <= {1'b0, mag};
            den_reg  <= den;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            rem_reg <= {kept[MAG_W-1:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
            if (last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

/* bench/dda_line_monitor.sv */
// Monitor that predicts the rasterizer's pixels from commands and checks the pixel channel.
`timescale 1ns / 1ps

module dda_line_monitor import dda_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    dda_in_if    cmd,
    dda_out_if   pix,
    output int   fail_count,
    output int   pending
);

    localparam int POS_BITS = COORD_BITS + FRAC_BITS + 1;

    typedef logic [POS_BITS-1:0]   pos_t;
    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS:0]   count_t;

    typedef struct packed
    {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   pixel_valid;
        logic   last_pixel;
    } pixel_t;

    localparam pos_t HALF = pos_t'(1) << (FRAC_BITS - 1);

    pos_t   x_pos;
    pos_t   y_pos;
    pos_t   x_inc;
    pos_t   y_inc;
    count_t steps_left;
    logic   line_on;
    pixel_t expected_pixels[$];
    int     errors;

    // Half-up rounding; the position is never negative on a legal line.
    function automatic coord_t round_pos(pos_t p);
        pos_t s;
        s = p + HALF;
        return s[FRAC_BITS +: COORD_BITS];
    endfunction

    // Per-step increment: magnitude truncated, then the sign of the delta applied.
    function automatic pos_t slope_of(coord_t a, coord_t b, count_t steps);
        pos_t mag;
        pos_t q;
        mag = (b < a) ? pos_t'(a - b) : pos_t'(b - a);
        q   = (mag << FRAC_BITS) / pos_t'(steps);
        return (b < a) ? -q : q;
    endfunction

    // Applies one command to the shadow line state and returns the pixel it yields.
    function automatic pixel_t advance_line(logic op, coord_t xs, coord_t ys,
                                            coord_t xe, coord_t ye);
        pixel_t px;
        coord_t adx;
        coord_t ady;
        count_t steps;
        px = '0;
        if (opcode_t'(op) == OP_START)
        begin
            adx   = (xe > xs) ? xe - xs : xs - xe;
            ady   = (ye > ys) ? ye - ys : ys - ye;
            steps = (adx > ady) ? count_t'(adx) : count_t'(ady);
            x_pos = pos_t'(xs) << FRAC_BITS;
            y_pos = pos_t'(ys) << FRAC_BITS;
            if (steps == '0)
            begin
                x_inc      = '0;
                y_inc      = '0;
                steps_left = '0;
                line_on    = 1'b0;
            end
            else
            begin
                x_inc      = slope_of(xs, xe, steps);
                y_inc      = slope_of(ys, ye, steps);
                steps_left = steps;
                line_on    = 1'b1;
            end
        end
        else if (!line_on)
        begin
            return px;
        end
        else
        begin
            x_pos      = x_pos + x_inc;
            y_pos      = y_pos + y_inc;
            steps_left = steps_left - 1'b1;
            if (steps_left == '0)
                line_on = 1'b0;
        end
        px.pixel_x     = round_pos(x_pos);
        px.pixel_y     = round_pos(y_pos);
        px.pixel_valid = 1'b1;
        px.last_pixel  = !line_on;
        return px;
    endfunction

    task automatic check_field(string name, coord_t want, coord_t got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Outputs are handled before inputs so that a command taken at this edge
    // can never be matched against a pixel taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            x_pos      = '0;
            y_pos      = '0;
            x_inc      = '0;
            y_inc      = '0;
            steps_left = '0;
            line_on    = 1'b0;
            expected_pixels.delete();
            errors     = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected pixel, expected none, actual %0d,%0d",
                             $time, pix.pixel_x, pix.pixel_y);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", want.pixel_x, pix.pixel_x);
                    check_field("pixel_y", want.pixel_y, pix.pixel_y);
                    check_field("pixel_valid", coord_t'(want.pixel_valid),
                                coord_t'(pix.pixel_valid));
                    check_field("last_pixel", coord_t'(want.last_pixel),
                                coord_t'(pix.last_pixel));
                end
            end
            if (cmd.valid && cmd.ready)
                expected_pixels.push_back(advance_line(cmd.opcode, cmd.x_start, cmd.y_start,
                                                       cmd.x_end, cmd.y_end));
            fail_count <= errors;
            pending    <= expected_pixels.size();
        end
    end

endmodule

/* bench/dda_line_rasterizer_top_tb.sv */
// Top of the line rasterizer testbench: clock, reset, command stimulus, pixel sink and verdict.
`timescale 1ns / 1ps

module dda_line_rasterizer_top_tb import dda_pkg::*; ();

    // Extra cycles allowed after the last pixel; a start with distinct
    // endpoints holds the command channel while both increments are divided.
    localparam int SETTLE_CYCLES = 2 * (FRAC_BITS_DEF + 1) + 8;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Idle percentages of the command sender and the pixel receiver.
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int items_sent    = 0;
    int fail_count;
    int pending;

    dda_in_if  cmd_if ();
    dda_out_if pix_if ();

    dda_line_rasterizer_top DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .pix   (pix_if)
    );

    // The monitor owns prediction and comparison; this module only drives
    // traffic and reports the outcome.
    dda_line_monitor u_monitor
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_if),
        .pix        (pix_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // The pixel receiver throttles on its own, one coin toss per cycle.
    always @(posedge clk)
    begin
        pix_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Offers one command and returns once its transfer has happened. The
    // valid line is left high so that back-to-back commands need no gap.
    task automatic send_item(opcode_t op, int xs, int ys, int xe, int ye);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.opcode  <= op;
        cmd_if.x_start <= COORD_BITS'(xs);
        cmd_if.y_start <= COORD_BITS'(ys);
        cmd_if.x_end   <= COORD_BITS'(xe);
        cmd_if.y_end   <= COORD_BITS'(ye);
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // A step carries coordinate fields too; they must be ignored, so they are random.
    task automatic send_step();
        send_item(OP_STEP, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                  $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    endtask

    // Holds the command channel quiet until every predicted pixel has been seen.
    // The monitor publishes its count through a register, hence the first wait.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Picks an endpoint within span of c, clamped to the screen so that the
    // borders show up often on long lines.
    function automatic int end_near(int c, int span);
        int e;
        e = c + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(span));
        if (e < 0)
            e = 0;
        if (e > COORD_MAX)
            e = COORD_MAX;
        return e;
    endfunction

    // One random line: a start followed mostly by exactly enough steps to
    // finish it. Some lines are cut short by the next start and some are run
    // past their end so that idle steps follow the last pixel.
    task automatic send_line();
        int xs;
        int ys;
        int xe;
        int ye;
        int span;
        int steps;
        int n_steps;
        int roll;
        roll = $urandom_range(99);
        span = (roll < 2) ? COORD_MAX : ((roll < 14) ? 200 : 15);
        xs   = $urandom_range(COORD_MAX);
        ys   = $urandom_range(COORD_MAX);
        xe   = end_near(xs, span);
        ye   = end_near(ys, span);
        steps = (xe > xs) ? xe - xs : xs - xe;
        if (((ye > ys) ? ye - ys : ys - ye) > steps)
            steps = (ye > ys) ? ye - ys : ys - ye;
        send_item(OP_START, xs, ys, xe, ye);
        roll = $urandom_range(99);
        if (roll < 10)
            n_steps = $urandom_range(steps);
        else if (roll < 20)
            n_steps = steps + $urandom_range(1, 3);
        else
            n_steps = steps;
        repeat (n_steps)
            send_step();
    endtask

    // One traffic phase with the given throttling, run until the running
    // item count reaches target, then drained.
    task automatic run_phase(int src_pct, int sink_pct, int target);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 5)
                send_item(opcode_t'($urandom_range(1)), $urandom_range(COORD_MAX),
                          $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                          $urandom_range(COORD_MAX));
            else
                send_line();
            // Now and then the sender stops until the pipeline is empty.
            if ($urandom_range(99) < 2)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        cmd_if.valid   <= 1'b0;
        cmd_if.opcode  <= OP_START;
        cmd_if.x_start <= '0;
        cmd_if.y_start <= '0;
        cmd_if.x_end   <= '0;
        cmd_if.y_end   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the sender eager and the receiver slow.
        src_idle_pct  = 29;
        sink_idle_pct = 77;
        // A step right after reset finds no line.
        send_step();
        // Equal endpoints at both corners: a single pixel marked last.
        send_item(OP_START, 0, 0, 0, 0);
        send_item(OP_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_step();
        // Full diagonal, then abandoned by a new start the other way across.
        send_item(OP_START, 0, 0, COORD_MAX, COORD_MAX);
        send_step();
        send_step();
        send_item(OP_START, COORD_MAX, 0, 0, COORD_MAX);
        send_step();
        send_step();
        // A half-pixel increment lands exactly on .5 and must round up.
        send_item(OP_START, 0, 0, 2, 1);
        send_step();
        send_step();
        send_step();
        // Steep line with both deltas negative, run one step past its end.
        send_item(OP_START, COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX - 5);
        repeat (6)
            send_step();
        // Single-step line.
        send_item(OP_START, 512, 511, 513, 511);
        send_step();
        wait_drained();

        // Random part in three throttling phases.
        run_phase(29, 77, 583);
        run_phase(77, 29, 1150);
        run_phase(0, 0, 1700);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("dda_line_rasterizer_top test passed");
        else
            $display("dda_line_rasterizer_top test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #20000000;
        $display("dda_line_rasterizer_top test failed");
        $finish;
    end

endmodule
